>>> rtl/pidac_pkg.sv
`default_nettype none
package pidac_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_CUTOFF   = 3'd5;

   // Request codes.
   localparam logic [1:0] REQ_ANGLE = 2'd0;
   localparam logic [1:0] REQ_RATE  = 2'd1;

   // Datapath operations.
   localparam int unsigned OP_W = 5;
   localparam logic [OP_W-1:0] OP_NOP         = 5'd0;
   localparam logic [OP_W-1:0] OP_CAPTURE     = 5'd1;
   localparam logic [OP_W-1:0] OP_MUL_ERR_DT  = 5'd2;
   localparam logic [OP_W-1:0] OP_DIV_INTEG   = 5'd3;
   localparam logic [OP_W-1:0] OP_INTEG_UPD   = 5'd4;
   localparam logic [OP_W-1:0] OP_DERIV_ZERO  = 5'd5;
   localparam logic [OP_W-1:0] OP_MUL_DERR    = 5'd6;
   localparam logic [OP_W-1:0] OP_DIV_DERIV   = 5'd7;
   localparam logic [OP_W-1:0] OP_DERIV_ANGLE = 5'd8;
   localparam logic [OP_W-1:0] OP_FILT_BYPASS = 5'd9;
   localparam logic [OP_W-1:0] OP_MUL_DTFC    = 5'd10;
   localparam logic [OP_W-1:0] OP_MUL_W       = 5'd11;
   localparam logic [OP_W-1:0] OP_DIV_ALPHA   = 5'd12;
   localparam logic [OP_W-1:0] OP_ALPHA_SET   = 5'd13;
   localparam logic [OP_W-1:0] OP_MUL_FILT    = 5'd14;
   localparam logic [OP_W-1:0] OP_FILT_UPD    = 5'd15;
   localparam logic [OP_W-1:0] OP_MUL_P       = 5'd16;
   localparam logic [OP_W-1:0] OP_MUL_I       = 5'd17;
   localparam logic [OP_W-1:0] OP_MUL_D       = 5'd18;
   localparam logic [OP_W-1:0] OP_SUM_ADD     = 5'd19;
   localparam logic [OP_W-1:0] OP_FINISH      = 5'd20;
   localparam logic [OP_W-1:0] OP_FINISH_CLR  = 5'd21;
   localparam logic [OP_W-1:0] OP_MUL_RECIP   = 5'd22;
   localparam logic [OP_W-1:0] OP_MUL_QBACK   = 5'd23;
   localparam logic [OP_W-1:0] OP_INTEG_FIX   = 5'd24;

   // Arithmetic constants.
   localparam logic [19:0] US_PER_S     = 20'd1000000;
   localparam logic [20:0] TWO_US_PER_S = 21'd2000000;
   localparam logic [18:0] HALF_US      = 19'd500000;
   localparam logic [28:0] RECIP_US     = 29'd281474976;
   localparam logic [18:0] TWO_PI_Q16   = 19'd411775;
   localparam logic [47:0] DEN_OFFSET   = 48'd65536000000;
   localparam int unsigned NUM_W      = 54;
   localparam int unsigned REM_W      = 48;
   localparam int unsigned CNT_W      = 6;
   localparam logic [CNT_W-1:0] STEPS_WIDE  = 6'd54;
   localparam logic [CNT_W-1:0] STEPS_ALPHA = 6'd31;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic is_clear;
      logic is_rate;
      logic dt_zero;
      logic bypass;
   } dp_status_type;

   function automatic logic signed [67:0] sx68(input logic signed [31:0] v);
      return {{36{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/pidac_ctrl.sv
`default_nettype none
module pidac_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   input  pidac_pkg::dp_status_type status,
   output pidac_pkg::dp_cmd_type    cmd
);
   import pidac_pkg::*;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_DECODE  = 5'd1;
   localparam logic [4:0] ST_IDIV_S  = 5'd2;
   localparam logic [4:0] ST_IDIV_W  = 5'd3;
   localparam logic [4:0] ST_DZERO   = 5'd4;
   localparam logic [4:0] ST_DMUL    = 5'd5;
   localparam logic [4:0] ST_DDIV_S  = 5'd6;
   localparam logic [4:0] ST_DDIV_W  = 5'd7;
   localparam logic [4:0] ST_BYPASS  = 5'd8;
   localparam logic [4:0] ST_DTFC    = 5'd9;
   localparam logic [4:0] ST_WMUL    = 5'd10;
   localparam logic [4:0] ST_ADIV_S  = 5'd11;
   localparam logic [4:0] ST_ADIV_W  = 5'd12;
   localparam logic [4:0] ST_FMUL    = 5'd13;
   localparam logic [4:0] ST_FUPD    = 5'd14;
   localparam logic [4:0] ST_MP      = 5'd15;
   localparam logic [4:0] ST_MI      = 5'd16;
   localparam logic [4:0] ST_MD      = 5'd17;
   localparam logic [4:0] ST_SUM     = 5'd18;
   localparam logic [4:0] ST_DONE    = 5'd19;
   localparam logic [4:0] ST_IRCP    = 5'd20;
   localparam logic [4:0] ST_IQB     = 5'd21;
   localparam logic [4:0] ST_IFIX    = 5'd22;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_clear) begin
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_MUL_ERR_DT;
               state_in = ST_IDIV_S;
            end
         end
         ST_IDIV_S: begin
            cmd.op   = OP_DIV_INTEG;
            state_in = ST_IRCP;
         end
         ST_IRCP: begin
            cmd.op   = OP_MUL_RECIP;
            state_in = ST_IQB;
         end
         ST_IQB: begin
            cmd.op   = OP_MUL_QBACK;
            state_in = ST_IFIX;
         end
         ST_IFIX: begin
            cmd.op   = OP_INTEG_FIX;
            state_in = ST_IDIV_W;
         end
         ST_IDIV_W: begin
            cmd.op = OP_INTEG_UPD;
            if (status.is_rate) begin
               state_in = status.bypass ? ST_BYPASS : ST_DTFC;
            end else begin
               state_in = status.dt_zero ? ST_DZERO : ST_DMUL;
            end
         end
         ST_DZERO: begin
            cmd.op   = OP_DERIV_ZERO;
            state_in = ST_MP;
         end
         ST_DMUL: begin
            cmd.op   = OP_MUL_DERR;
            state_in = ST_DDIV_S;
         end
         ST_DDIV_S: begin
            cmd.op   = OP_DIV_DERIV;
            state_in = ST_DDIV_W;
         end
         ST_DDIV_W: begin
            if (status.div_done) begin
               cmd.op   = OP_DERIV_ANGLE;
               state_in = ST_MP;
            end
         end
         ST_BYPASS: begin
            cmd.op   = OP_FILT_BYPASS;
            state_in = ST_MP;
         end
         ST_DTFC: begin
            cmd.op   = OP_MUL_DTFC;
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            cmd.op   = OP_MUL_W;
            state_in = ST_ADIV_S;
         end
         ST_ADIV_S: begin
            cmd.op   = OP_DIV_ALPHA;
            state_in = ST_ADIV_W;
         end
         ST_ADIV_W: begin
            if (status.div_done) begin
               cmd.op   = OP_ALPHA_SET;
               state_in = ST_FMUL;
            end
         end
         ST_FMUL: begin
            cmd.op   = OP_MUL_FILT;
            state_in = ST_FUPD;
         end
         ST_FUPD: begin
            cmd.op   = OP_FILT_UPD;
            state_in = ST_MP;
         end
         ST_MP: begin
            cmd.op   = OP_MUL_P;
            state_in = ST_MI;
         end
         ST_MI: begin
            cmd.op   = OP_MUL_I;
            state_in = ST_MD;
         end
         ST_MD: begin
            cmd.op   = OP_MUL_D;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM_ADD;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = status.is_clear ? OP_FINISH_CLR : OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> rtl/pidac_dp.sv
`default_nettype none
module pidac_dp (
   input  wire                      clock,
   input  wire                      reset,
   input  pidac_pkg::dp_cmd_type    cmd,
   output pidac_pkg::dp_status_type status,
   input  wire  [1:0]               req_type,
   input  wire  signed [31:0]       req_setpoint,
   input  wire  signed [31:0]       req_measurement,
   input  wire  signed [31:0]       req_gyro_rate,
   input  wire  [15:0]              req_dt_us,
   output logic signed [31:0]       rsp_control_output,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [pidac_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0]              csr_data
);
   import pidac_pkg::*;

   // Configuration.
   logic signed [31:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [30:0]        integral_limit_ff, output_limit_ff;
   logic [9:0]         cutoff_ff;

   // Controller state.
   logic signed [31:0] integ_ff, integ_in;
   logic signed [31:0] last_err_ff, last_err_in;
   logic signed [31:0] filt_ff, filt_in;

   // Working registers.
   logic [1:0]         type_ff, type_in;
   logic signed [31:0] gyro_ff, gyro_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] deriv_ff, deriv_in;
   logic [30:0]        alpha_ff, alpha_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [67:0] sum_ff, sum_in;
   logic signed [31:0] result_ff, result_in;

   // Divider.
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic signed [32:0] mul_a, mul_b;
   logic               mul_en;
   logic               prod_neg;
   logic [65:0]        prod_mag;
   logic [REM_W-1:0]   trial;
   logic signed [54:0] quo_s;
   logic signed [67:0] acc_sum, lim_i, lim_o, rnd;
   logic [31:0]        alpha_inc;
   logic [35:0]        fq;
   logic signed [36:0] fs;
   logic signed [31:0] fnew;
   logic [22:0]        rem_lo;
   logic [1:0]         quo_fix;

   assign prod_neg  = prod_ff[65];
   assign prod_mag  = prod_neg ? 66'(-prod_ff) : 66'(prod_ff);
   assign trial     = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign quo_s     = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign lim_i     = {37'd0, integral_limit_ff};
   assign lim_o     = {37'd0, output_limit_ff};
   assign acc_sum   = sx68(integ_ff) + {{13{quo_s[54]}}, quo_s};
   assign alpha_inc = {1'b0, quo_ff[30:0]} + 32'd1;
   assign fq        = 36'((prod_mag + 66'd536870912) >> 30);
   assign fs        = prod_neg ? -$signed({1'b0, fq}) : $signed({1'b0, fq});
   assign fnew      = sat32(sx68(filt_ff) + {{31{fs[36]}}, fs});
   assign rnd       = (sum_ff + 68'sd32768) >>> 16;

   // The reciprocal estimate of the integral quotient falls short by at most two, so the
   // remainder is below 2^23 and its low bits alone decide the correction.
   assign rem_lo  = num_ff[22:0] - prod_ff[22:0];
   assign quo_fix = (rem_lo >= {2'd0, TWO_US_PER_S}) ? 2'd2 :
                    (rem_lo >= {3'd0, US_PER_S}) ? 2'd1 : 2'd0;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (cmd.op)
         OP_MUL_ERR_DT: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {17'd0, dt_ff};
         end
         OP_MUL_RECIP: begin
            mul_a = {1'b0, num_ff[47:16]};
            mul_b = {4'd0, RECIP_US};
         end
         OP_MUL_QBACK: begin
            mul_a = {4'd0, prod_ff[60:32]};
            mul_b = {13'd0, US_PER_S};
         end
         OP_MUL_DERR: begin
            mul_a = {err_ff[31], err_ff} - {last_err_ff[31], last_err_ff};
            mul_b = {13'd0, US_PER_S};
         end
         OP_MUL_DTFC: begin
            mul_a = {17'd0, dt_ff};
            mul_b = {23'd0, cutoff_ff};
         end
         OP_MUL_W: begin
            mul_a = prod_ff[32:0];
            mul_b = {14'd0, TWO_PI_Q16};
         end
         OP_MUL_FILT: begin
            mul_a = {gyro_ff[31], gyro_ff} - {filt_ff[31], filt_ff};
            mul_b = {2'd0, alpha_ff};
         end
         OP_MUL_P: begin
            mul_a = {prop_gain_ff[31], prop_gain_ff};
            mul_b = {err_ff[31], err_ff};
         end
         OP_MUL_I: begin
            mul_a = {integ_gain_ff[31], integ_gain_ff};
            mul_b = {integ_ff[31], integ_ff};
         end
         OP_MUL_D: begin
            mul_a = {deriv_gain_ff[31], deriv_gain_ff};
            mul_b = {deriv_ff[31], deriv_ff};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
      prod_in = mul_en ? mul_a * mul_b : prod_ff;
   end

   always_comb begin
      type_in     = type_ff;
      gyro_in     = gyro_ff;
      dt_in       = dt_ff;
      err_in      = err_ff;
      deriv_in    = deriv_ff;
      alpha_in    = alpha_ff;
      sum_in      = sum_ff;
      result_in   = result_ff;
      integ_in    = integ_ff;
      last_err_in = last_err_ff;
      filt_in     = filt_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      quo_in      = quo_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;

      // One restoring step per cycle while a division is running.
      if (cnt_ff != '0) begin
         if (trial >= den_ff) begin
            rem_in = trial - den_ff;
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end

      unique case (cmd.op)
         OP_CAPTURE: begin
            type_in = req_type;
            gyro_in = req_gyro_rate;
            dt_in   = req_dt_us;
            err_in  = sat32(sx68(req_setpoint) - sx68(req_measurement));
         end
         OP_DIV_INTEG: begin
            // Rounded magnitude of error times dt, divided by 10^6 through a reciprocal.
            num_in = prod_mag[NUM_W-1:0] + {35'd0, HALF_US};
            neg_in = prod_neg;
         end
         OP_MUL_QBACK: begin
            quo_in = {25'd0, prod_ff[60:32]};
         end
         OP_INTEG_FIX: begin
            quo_in = quo_ff + {52'd0, quo_fix};
         end
         OP_DIV_DERIV: begin
            num_in = prod_mag[NUM_W-1:0] + {39'd0, dt_ff[15:1]};
            den_in = {32'd0, dt_ff};
            rem_in = '0;
            quo_in = '0;
            neg_in = prod_neg;
            cnt_in = STEPS_WIDE;
         end
         OP_DIV_ALPHA: begin
            // Fraction w / (w + 2^16 * 10^6) as 31 quotient bits.
            num_in = '0;
            rem_in = prod_ff[REM_W-1:0];
            den_in = prod_ff[REM_W-1:0] + DEN_OFFSET;
            quo_in = '0;
            neg_in = 1'b0;
            cnt_in = STEPS_ALPHA;
         end
         OP_INTEG_UPD: begin
            if (acc_sum > lim_i) begin
               integ_in = lim_i[31:0];
            end else if (acc_sum < -lim_i) begin
               integ_in = 32'(-lim_i);
            end else begin
               integ_in = acc_sum[31:0];
            end
         end
         OP_DERIV_ZERO: begin
            deriv_in = '0;
         end
         OP_DERIV_ANGLE: begin
            deriv_in = sat32({{13{quo_s[54]}}, quo_s});
         end
         OP_FILT_BYPASS: begin
            filt_in  = gyro_ff;
            deriv_in = sat32(-sx68(gyro_ff));
         end
         OP_ALPHA_SET: begin
            alpha_in = alpha_inc[31:1];
         end
         OP_FILT_UPD: begin
            filt_in  = fnew;
            deriv_in = sat32(-sx68(fnew));
         end
         OP_MUL_I: begin
            sum_in = {{2{prod_ff[65]}}, prod_ff};
         end
         OP_MUL_D, OP_SUM_ADD: begin
            sum_in = sum_ff + {{2{prod_ff[65]}}, prod_ff};
         end
         OP_FINISH: begin
            last_err_in = err_ff;
            if (rnd > lim_o) begin
               result_in = lim_o[31:0];
            end else if (rnd < -lim_o) begin
               result_in = 32'(-lim_o);
            end else begin
               result_in = rnd[31:0];
            end
         end
         OP_FINISH_CLR: begin
            integ_in    = '0;
            last_err_in = '0;
            filt_in     = '0;
            result_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= '0;
         integ_gain_ff     <= '0;
         deriv_gain_ff     <= '0;
         integral_limit_ff <= '0;
         output_limit_ff   <= '0;
         cutoff_ff         <= 10'd60;
         integ_ff          <= '0;
         last_err_ff       <= '0;
         filt_ff           <= '0;
         cnt_ff            <= '0;
      end else begin
         integ_ff    <= integ_in;
         last_err_ff <= last_err_in;
         filt_ff     <= filt_in;
         cnt_ff      <= cnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PROP_GAIN:      prop_gain_ff      <= csr_data;
               CSR_INTEG_GAIN:     integ_gain_ff     <= csr_data;
               CSR_DERIV_GAIN:     deriv_gain_ff     <= csr_data;
               CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_data[30:0];
               CSR_OUTPUT_LIMIT:   output_limit_ff   <= csr_data[30:0];
               CSR_DERIV_CUTOFF:   cutoff_ff         <= csr_data[9:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      gyro_ff   <= gyro_in;
      dt_ff     <= dt_in;
      err_ff    <= err_in;
      deriv_ff  <= deriv_in;
      alpha_ff  <= alpha_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      result_ff <= result_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
   end

   assign status.div_done = (cnt_ff == '0);
   assign status.is_clear = type_ff[1];
   assign status.is_rate  = (type_ff == REQ_RATE);
   assign status.dt_zero  = (dt_ff == '0);
   assign status.bypass   = (dt_ff == '0) || (cutoff_ff == '0);

   assign rsp_control_output = result_ff;
   assign csr_ready          = 1'b1;

endmodule
`default_nettype wire

>>> rtl/pid_angle_controller.sv
// A clear goes straight from decode to the result; an angle update with a nonzero dt
// runs the derivative divide, a rate update through the filter runs the alpha divide,
// and an update with dt of zero or the filter bypassed has no divide of its own.
// Throughput: one transaction at a time; the shared divider resolves 1 bit per cycle.
// Reset: synchronous, active high; clears gains and limits, sets the cutoff to 60 Hz and
// zeroes the integral, last error and filtered rate.
`default_nettype none
module pid_angle_controller (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire  [1:0]        req_type,
   input  wire  signed [31:0] req_setpoint,
   input  wire  signed [31:0] req_measurement,
   input  wire  signed [31:0] req_gyro_rate,
   input  wire  [15:0]       req_dt_us,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [31:0] rsp_control_output,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [pidac_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0]       csr_data
);
   import pidac_pkg::*;

   // The controller sequences the operations of one transaction; the datapath holds the
   // configuration, the controller state, one shared 33 by 33 multiplier with a registered
   // product, and a restoring divider that resolves one quotient bit per cycle. The integral
   // step divides by one million through a reciprocal product and a small correction.
   dp_cmd_type    cmd;
   dp_status_type status;

   pidac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The result register in the datapath parts the two sides: a new transaction is taken
   // while the previous result still waits, and it is only held back at the final step.
   pidac_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_setpoint       (req_setpoint),
      .req_measurement    (req_measurement),
      .req_gyro_rate      (req_gyro_rate),
      .req_dt_us          (req_dt_us),
      .rsp_control_output (rsp_control_output),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Only one transaction is in flight, so acceptance always closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while one is in flight");

   // The divider must be idle whenever a new transaction can be taken.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> status.div_done)
      else $error("divider busy while idle");

   // A result appears only at the end of a sequence, never straight out of idle.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised without a completed sequence");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
   import pidac_pkg::*;

   // The package names only the two update codes. Code 2 is a clear, and the
   // spare code 3 must behave the same way.
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned HOLD_CYCLES = 400;

   // Software copy of the controller. It keeps its own registers and loop
   // state, works out the drive value for every accepted transaction, and
   // compares the returned values against that queue in order.
   class pid_scoreboard;
      longint kp, ki, kd, integ_lim, out_lim, cutoff_hz;
      longint integ, prev_err, filt_rate;
      logic signed [31:0] drive_q[$];
      int unsigned errors;

      function void clear_all();
         kp = 0;
         ki = 0;
         kd = 0;
         integ_lim = 0;
         out_lim = 0;
         cutoff_hz = 60;
         integ = 0;
         prev_err = 0;
         filt_rate = 0;
         drive_q.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_PROP_GAIN: kp = longint'(int'(data));
            CSR_INTEG_GAIN: ki = longint'(int'(data));
            CSR_DERIV_GAIN: kd = longint'(int'(data));
            CSR_INTEGRAL_LIMIT: integ_lim = longint'(data[30:0]);
            CSR_OUTPUT_LIMIT: out_lim = longint'(data[30:0]);
            CSR_DERIV_CUTOFF: cutoff_hz = longint'(data[9:0]);
            default: ;
         endcase
      endfunction

      // Divide with rounding to nearest, ties away from zero.
      function longint round_div(longint n, longint d);
         longint m, q;
         m = (n < 0) ? -n : n;
         q = (m + d / 2) / d;
         return (n < 0) ? -q : q;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Alpha in unsigned Q1.30, built by a restoring divide like the hardware.
      function longint filter_alpha(longint dt);
         longint w, den, rem, quo;
         w = dt * cutoff_hz * 64'sd411775;
         den = w + 64'sd65536000000;
         rem = w;
         quo = 0;
         for (int i = 0; i < 31; i++) begin
            rem = rem <<< 1;
            quo = quo <<< 1;
            if (rem >= den) begin
               rem = rem - den;
               quo = quo | 1;
            end
         end
         return (quo + 1) >>> 1;
      endfunction

      function void note_request(logic [1:0] kind, logic signed [31:0] sp,
                                 logic signed [31:0] ms, logic signed [31:0] gyro,
                                 logic [15:0] dt_us);
         longint err, acc, deriv, dt, p, qs, rs, sum;
         dt = longint'(dt_us);
         if (kind == REQ_CLEAR || kind == REQ_SPARE) begin
            integ = 0;
            prev_err = 0;
            filt_rate = 0;
            drive_q.push_back(32'sd0);
            return;
         end
         err = clip32(longint'(sp) - longint'(ms));
         acc = integ + round_div(err * dt, 1000000);
         if (acc > integ_lim) acc = integ_lim;
         if (acc < -integ_lim) acc = -integ_lim;
         integ = acc;
         if (kind == REQ_ANGLE) begin
            deriv = 0;
            if (dt != 0) deriv = clip32(round_div((err - prev_err) * 1000000, dt));
         end else begin
            if (cutoff_hz != 0 && dt != 0) begin
               filt_rate = clip32(filt_rate + round_div((longint'(gyro) - filt_rate)
                                  * filter_alpha(dt), 64'sd1 <<< 30));
            end else begin
               filt_rate = longint'(gyro);
            end
            deriv = clip32(-filt_rate);
         end
         prev_err = err;
         // Each Q32.32 product splits into a floored Q16.16 part and the
         // 16 fraction bits; the fractions are summed before rounding.
         p = kp * err;
         qs = p >>> 16;
         rs = p & 64'hFFFF;
         p = ki * integ;
         qs += p >>> 16;
         rs += p & 64'hFFFF;
         p = kd * deriv;
         qs += p >>> 16;
         rs += p & 64'hFFFF;
         sum = qs + (rs + 32768) / 65536;
         if (sum > out_lim) sum = out_lim;
         if (sum < -out_lim) sum = -out_lim;
         drive_q.push_back(sum[31:0]);
      endfunction

      function void check_result(logic signed [31:0] got);
         logic signed [31:0] want;
         if (drive_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result %0d", got);
            return;
         end
         want = drive_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: control_output expected %0d got %0d", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_type;
   logic signed [31:0] req_setpoint, req_measurement, req_gyro_rate;
   logic [15:0] req_dt_us;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_control_output;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;

   pid_scoreboard board;
   int unsigned req_idle_pct, rsp_idle_pct;
   int unsigned cycle_count;
   logic hold_go, rsp_hold;

   pid_angle_controller u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_setpoint(req_setpoint),
      .req_measurement(req_measurement),
      .req_gyro_rate(req_gyro_rate),
      .req_dt_us(req_dt_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_control_output(rsp_control_output),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both monitors sample at the rising edge, while all stimulus moves on the
   // falling edge, so the values seen here are stable for the whole edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_type, req_setpoint, req_measurement, req_gyro_rate,
                            req_dt_us);
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_control_output);
   end

   // The result side stalls at random at the current rate, and all the time
   // while a long hold is running.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // The long hold lives in its own process and counts its own cycles. While
   // it runs, the sender keeps offering transactions, so the block ends up
   // with a finished result it cannot return and has to refuse new work.
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      @(negedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold = 1'b0;
   end

   // Hard stop in case the block hangs on a handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one request transaction. Valid is not dropped between
   // back-to-back transactions, so it never sees two assignments in a step.
   task automatic send_request(logic [1:0] kind, logic [31:0] sp, logic [31:0] ms,
                               logic [31:0] gyro, logic [15:0] dt);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_setpoint <= sp;
      req_measurement <= ms;
      req_gyro_rate <= gyro;
      req_dt_us <= dt;
      do @(posedge clock); while (!req_ready);
   endtask

   // Wait until every expected result has come back, then give the block
   // time to settle before anything else touches it.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.drive_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                            logic [31:0] ilim, logic [31:0] olim, logic [31:0] fc);
      write_csr(CSR_PROP_GAIN, kp);
      write_csr(CSR_INTEG_GAIN, ki);
      write_csr(CSR_DERIV_GAIN, kd);
      write_csr(CSR_INTEGRAL_LIMIT, ilim);
      write_csr(CSR_OUTPUT_LIMIT, olim);
      write_csr(CSR_DERIV_CUTOFF, fc);
   endtask

   // Gains are mostly modest so that the clamps do not hide the arithmetic,
   // with the occasional full-range value.
   function automatic logic [31:0] pick_gain();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return 32'($urandom_range(0, 32'h0100_0000));
      endcase
   endfunction

   function automatic logic [31:0] pick_signal();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000);
      endcase
   endfunction

   function automatic logic [15:0] pick_dt();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'($urandom);
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1, 5000));
      endcase
   endfunction

   task automatic random_requests(int unsigned count, bit with_hold);
      logic [1:0] kind;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         if (with_hold && n == count / 3) hold_go = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 45) kind = REQ_ANGLE;
         else if (pick < 90) kind = REQ_RATE;
         else kind = 2'($urandom_range(2, 3));
         send_request(kind, pick_signal(), pick_signal(), pick_signal(), pick_dt());
      end
   endtask

   initial begin
      board = new();
      board.clear_all();
      cycle_count = 0;
      hold_go = 1'b0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_ANGLE;
      req_setpoint = '0;
      req_measurement = '0;
      req_gyro_rate = '0;
      req_dt_us = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PROP_GAIN;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset values: all gains zero, so even extreme inputs give zero.
      send_request(REQ_ANGLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF);
      drain();

      // Directed part with unit proportional and integral gains, a small derivative gain and open limits.
      write_all(32'h0001_0000, 32'h0001_0000, 32'h0000_0100, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'd60);
      send_request(REQ_ANGLE, 32'h0001_0000, 32'h0, 32'h0, 16'd1000);
      send_request(REQ_ANGLE, 32'h0002_0000, 32'h0, 32'h0, 16'd0);       // zero dt
      send_request(REQ_ANGLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd1);   // error clips high
      send_request(REQ_ANGLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'hFFFF); // error clips low
      send_request(REQ_RATE, 32'h0, 32'h0001_0000, 32'h0010_0000, 16'd2500);
      send_request(REQ_RATE, 32'h0, 32'h0, 32'h8000_0000, 16'd0);  // bypass on zero dt
      send_request(REQ_RATE, 32'h0, 32'h0, 32'h7FFF_FFFF, 16'hFFFF);
      send_request(REQ_CLEAR, 32'h1234_5678, 32'h0, 32'h0, 16'd100);
      send_request(REQ_RATE, 32'h0, 32'h0, 32'h8000_0000, 16'd100);
      send_request(REQ_SPARE, 32'h0, 32'h0, 32'h0, 16'd0);          // spare code clears
      drain();

      // Filter off, tight clamps, largest negative gains.
      write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000,
                32'h0000_8000, 32'd0);
      send_request(REQ_RATE, 32'h0100_0000, 32'h0, 32'h0300_0000, 16'd500);
      send_request(REQ_ANGLE, 32'hFF00_0000, 32'h0, 32'h0, 16'd500);
      send_request(REQ_RATE, 32'h0, 32'h0100_0000, 32'hFFFF_FFFF, 16'd1);
      drain();

      // Cutoff beyond the nominal range and the largest gains.
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'd1023);
      send_request(REQ_RATE, 32'h0, 32'h0, 32'h4000_0000, 16'hFFFF);
      send_request(REQ_ANGLE, 32'h0000_0001, 32'h0, 32'h0, 16'd3);
      drain();
      write_csr(CSR_OUTPUT_LIMIT, 32'hFFFF_FFFF);
      send_request(REQ_RATE, 32'h0, 32'h0, 32'hC000_0000, 16'd1);
      send_request(REQ_ANGLE, 32'h8000_0000, 32'h0, 32'h0, 16'd7);
      drain();

      // Random part in three idling phases, each with fresh settings. The
      // drain between phases also makes the sender wait for every result.
      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 84 : 0;
         rsp_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 30 : 0;
         for (int blk = 0; blk < 4; blk++) begin
            write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1000));
            random_requests(132, ph == 2 && blk == 1);
            drain();
         end
      end

      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.drive_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/pidac_pkg.sv
rtl/pidac_ctrl.sv
rtl/pidac_dp.sv
rtl/pid_angle_controller.sv
tb/testbench.sv
